FILE: src/rsp_pkg.sv
package rsp_pkg;

  // Fixed field widths of the byte stream and of the result item.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ADDR_W   = 6;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 40;
  localparam int unsigned M_USER_W = 2;

  // Parser phase codes.
  localparam logic [2:0] PH_STOPPED = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // Range of SDES item types that are recognised (CNAME through NOTE).
  localparam logic [BYTE_W-1:0] TYPE_NULL      = 8'd0;
  localparam logic [BYTE_W-1:0] TYPE_KNOWN_MIN = 8'd1;
  localparam logic [BYTE_W-1:0] TYPE_KNOWN_MAX = 8'd7;

  // One packet byte with its framing marks.
  typedef struct packed {
    logic              last_byte;
    logic              first_byte;
    logic [BYTE_W-1:0] pkt_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic              parse_done;
    logic              known_type;
    logic [LEN_W-1:0]  item_length;
    logic [ADDR_W-1:0] item_offset;
    logic [BYTE_W-1:0] item_type;
    logic              item_valid;
    logic [BYTE_W-1:0] store_data;
    logic [ADDR_W-1:0] store_addr;
    logic              store_valid;
  } res_item_t;

endpackage

FILE: src/rsp_in_reg.sv
module rsp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rsp_pkg::in_item_t item_i,
  input  logic              take_i,
  output logic              valid_o,
  output rsp_pkg::in_item_t item_o
);
  import rsp_pkg::*;

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;

  // Occupancy: a load refills the stage, a take without a load empties it.
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/rsp_core.sv
module rsp_core #(
  parameter int unsigned BUF_BYTES    = 64,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  rsp_pkg::in_item_t  item_i,
  output rsp_pkg::res_item_t res_o
);
  import rsp_pkg::*;

  localparam int unsigned PW    = $clog2(BUF_BYTES);
  localparam int unsigned HCW   = $clog2(HEADER_BYTES);
  localparam int unsigned SUM_W = ((PW > BYTE_W) ? PW : BYTE_W) + 1;

  logic [2:0]        phase_q, phase_d;
  logic [HCW-1:0]    hdr_cnt_q, hdr_cnt_d;
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     item_start_q, item_start_d;
  logic [BYTE_W-1:0] cur_type_q, cur_type_d;
  logic [BYTE_W-1:0] cur_len_q, cur_len_d;
  logic [BYTE_W-1:0] bytes_left_q, bytes_left_d;
  logic              cur_kept_q, cur_kept_d;

  // Working copies of the state, cleared when a first byte restarts the parse.
  logic [2:0]        ph;
  logic [HCW-1:0]    hc;
  logic [PW-1:0]     wp;
  logic [PW-1:0]     ist;
  logic [BYTE_W-1:0] ct;
  logic [BYTE_W-1:0] cl;
  logic [BYTE_W-1:0] bl;
  logic              ck;

  logic [HCW:0]          hc_inc;
  logic [SUM_W-1:0]      room_sum;
  logic                  fits;
  logic [BYTE_W-1:0]     bl_dec;
  logic [PW+ADDR_W-1:0]  wp_ext;
  logic [PW+ADDR_W-1:0]  ist_ext;
  logic [PW+ADDR_W-1:0]  wp_len_ext;
  logic [BYTE_W-1:0]     b;
  logic                  last;
  res_item_t             res;

  assign b    = item_i.pkt_byte;
  assign last = item_i.last_byte;

  always_comb begin
    if (item_i.first_byte) begin
      ph  = PH_HEADER;
      hc  = '0;
      wp  = '0;
      ist = '0;
      ct  = '0;
      cl  = '0;
      bl  = '0;
      ck  = 1'b0;
    end else begin
      ph  = phase_q;
      hc  = hdr_cnt_q;
      wp  = wr_ptr_q;
      ist = item_start_q;
      ct  = cur_type_q;
      cl  = cur_len_q;
      bl  = bytes_left_q;
      ck  = cur_kept_q;
    end
  end

  // Helper values for the header count, the room check and address fields.
  assign hc_inc     = {1'b0, hc} + {{HCW{1'b0}}, 1'b1};
  assign room_sum   = SUM_W'(wp) + SUM_W'(b);
  assign fits       = room_sum < SUM_W'(BUF_BYTES);
  assign bl_dec     = (bl != '0) ? (bl - 8'd1) : bl;
  assign wp_ext     = {{ADDR_W{1'b0}}, wp};
  assign ist_ext    = {{ADDR_W{1'b0}}, ist};
  assign wp_len_ext = {{PW{1'b0}}, b[LEN_W-1:0]};

  // Parse step: next state and the result item for this byte.
  always_comb begin
    phase_d      = ph;
    hdr_cnt_d    = hc;
    wr_ptr_d     = wp;
    item_start_d = ist;
    cur_type_d   = ct;
    cur_len_d    = cl;
    bytes_left_d = bl;
    cur_kept_d   = ck;
    res          = '0;
    case (ph)
      PH_HEADER: begin
        if (hc_inc >= (HCW+1)'(HEADER_BYTES)) begin
          hdr_cnt_d = '0;
          phase_d   = PH_TYPE;
        end else begin
          hdr_cnt_d = hc_inc[HCW-1:0];
        end
        if (last) begin
          phase_d        = PH_STOPPED;
          res.parse_done = 1'b1;
        end
      end
      PH_TYPE: begin
        cur_type_d = b;
        if (b == TYPE_NULL || last) begin
          phase_d        = PH_STOPPED;
          res.parse_done = 1'b1;
        end else begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        cur_len_d    = b;
        bytes_left_d = b;
        item_start_d = wp;
        cur_kept_d   = fits;
        if (b == '0) begin
          if (fits) begin
            res.item_valid  = 1'b1;
            res.item_type   = ct;
            res.item_offset = wp_ext[ADDR_W-1:0];
            res.item_length = wp_len_ext[LEN_W-1:0];
            res.known_type  = (ct >= TYPE_KNOWN_MIN) && (ct <= TYPE_KNOWN_MAX);
          end
          phase_d = PH_TYPE;
          if (last) begin
            phase_d        = PH_STOPPED;
            res.parse_done = 1'b1;
          end
        end else if (last) begin
          phase_d        = PH_STOPPED;
          res.parse_done = 1'b1;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (ck) begin
          res.store_valid = 1'b1;
          res.store_addr  = wp_ext[ADDR_W-1:0];
          res.store_data  = b;
          wr_ptr_d        = wp + PW'(1);
        end
        bytes_left_d = bl_dec;
        if (bl_dec == '0) begin
          if (ck) begin
            res.item_valid  = 1'b1;
            res.item_type   = ct;
            res.item_offset = ist_ext[ADDR_W-1:0];
            res.item_length = cl[LEN_W-1:0];
            res.known_type  = (ct >= TYPE_KNOWN_MIN) && (ct <= TYPE_KNOWN_MAX);
          end
          phase_d = PH_TYPE;
          if (last) begin
            phase_d        = PH_STOPPED;
            res.parse_done = 1'b1;
          end
        end else if (last) begin
          // Item cut short by the end of the packet: rewind the write pointer.
          wr_ptr_d       = ist;
          phase_d        = PH_STOPPED;
          res.parse_done = 1'b1;
        end
      end
      PH_STOPPED: begin
        phase_d = PH_STOPPED;
      end
      default: begin
        phase_d = PH_STOPPED;
      end
    endcase
  end

  // Parser state advances only when a byte moves on to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_STOPPED;
      hdr_cnt_q    <= '0;
      wr_ptr_q     <= '0;
      item_start_q <= '0;
      cur_type_q   <= '0;
      cur_len_q    <= '0;
      bytes_left_q <= '0;
      cur_kept_q   <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      hdr_cnt_q    <= hdr_cnt_d;
      wr_ptr_q     <= wr_ptr_d;
      item_start_q <= item_start_d;
      cur_type_q   <= cur_type_d;
      cur_len_q    <= cur_len_d;
      bytes_left_q <= bytes_left_d;
      cur_kept_q   <= cur_kept_d;
    end
  end

  assign res_o = res;

endmodule

FILE: src/rsp_out_reg.sv
module rsp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  rsp_pkg::res_item_t res_i,
  input  logic               ready_i,
  output logic               valid_o,
  output rsp_pkg::res_item_t res_o
);
  import rsp_pkg::*;

  logic      valid_q;
  logic      valid_d;
  res_item_t res_q;

  // A new result replaces the held one; a transfer without a load empties it.
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: src/rtcp_sdes_item_parser.sv
// Channel  Direction  Signals                       Contents
// s_axis   in         tvalid tready tdata tuser     one packet byte
//                     tlast                         tlast = last byte of packet
// m_axis   out        tvalid tready tdata tuser     one result per packet byte
//                     tlast                         tlast = parsing has ended
//
// Each byte passes from its transfer in through the input register, then
// through the parse logic into the result register.
// One byte is accepted every cycle while the result side takes one per cycle.
// Reset clears the parser to its stopped phase and empties both registers.
// A stalled result side holds the result register; the input register still
// takes one more byte before the input side stalls.
module rtcp_sdes_item_parser #(
  parameter int unsigned BUF_BYTES    = 64,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // pkt_byte [7:0]
  input  logic [rsp_pkg::S_DATA_W-1:0]  s_axis_tdata_i,
  // first_byte
  input  logic                          s_axis_tuser_i,
  // last_byte
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // store_addr [5:0], store_data [13:6], item_type [21:14], item_offset [27:22],
  // item_length [33:28], known_type [34], zero [39:35]
  output logic [rsp_pkg::M_DATA_W-1:0]  m_axis_tdata_o,
  // store_valid [0], item_valid [1]
  output logic [rsp_pkg::M_USER_W-1:0]  m_axis_tuser_o,
  // parse_done
  output logic                          m_axis_tlast_o
);
  import rsp_pkg::*;

  in_item_t  s_item;
  in_item_t  held_item;
  res_item_t step_res;
  res_item_t out_res;
  logic      held_valid;
  logic      out_valid;
  logic      advance;
  logic      s_xfer;

  // A byte moves into the result register when that register is free or drains.
  assign advance         = held_valid && (!out_valid || m_axis_tready_i);
  assign s_axis_tready_o = !held_valid || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  assign s_item.pkt_byte   = s_axis_tdata_i;
  assign s_item.first_byte = s_axis_tuser_i;
  assign s_item.last_byte  = s_axis_tlast_i;

  rsp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s_xfer),
    .item_i  (s_item),
    .take_i  (advance),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  rsp_core #(
    .BUF_BYTES    (BUF_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (held_item),
    .res_o  (step_res)
  );

  rsp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (step_res),
    .ready_i (m_axis_tready_i),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  // Pack the result fields onto the master side.
  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {5'b0, out_res.known_type, out_res.item_length,
                            out_res.item_offset, out_res.item_type,
                            out_res.store_data, out_res.store_addr};
  assign m_axis_tuser_o  = {out_res.item_valid, out_res.store_valid};
  assign m_axis_tlast_o  = out_res.parse_done;

endmodule

FILE: src/rsp_checker.sv
module rsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import rsp_pkg::*;

  // A stalled result holds its whole payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Without a buffer write the write fields are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[13:0] == 14'd0)
    else $error("write fields set without a buffer write");

  // Without a descriptor the descriptor fields are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[1] |-> m_axis_tdata_o[34:14] == 21'd0)
    else $error("descriptor fields set without a descriptor");

  // The known flag matches the type range of the descriptor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |->
      m_axis_tdata_o[34] == ((m_axis_tdata_o[21:14] >= TYPE_KNOWN_MIN)
                             && (m_axis_tdata_o[21:14] <= TYPE_KNOWN_MAX)))
    else $error("known flag disagrees with item type");

  // A byte taken into an empty pipeline shows up as a result after the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o && s_axis_tvalid_i && s_axis_tready_o ##1 !m_axis_tvalid_o
      |=> m_axis_tvalid_o)
    else $error("accepted byte produced no result");

endmodule

bind rtcp_sdes_item_parser rsp_checker u_rsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

FILE: verif/rtcp_sdes_item_parser_tb.sv
`timescale 1ns / 1ps

module rtcp_sdes_item_parser_tb;

  import rsp_pkg::*;

  localparam int unsigned BUF_SIZE        = 64;
  localparam int unsigned HDR_BYTES       = 8;
  localparam int unsigned CLK_HALF        = 4;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned RAND_BYTES      = 1350;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned DIR_ROWS        = 40;

  // How a row of the directed table is checked.
  typedef enum logic [2:0] {
    EXP_PRED,
    EXP_IDLE,
    EXP_DONE,
    EXP_DESC,
    EXP_WRITE
  } check_kind_e;

  // One directed row: the byte with its marks and, where typed in, its result.
  // For a descriptor code/pos/len/known are type, offset, length and known flag;
  // for a buffer write code is the data and pos the address.
  typedef struct packed {
    logic [7:0]  pkt;
    logic        first;
    logic        last;
    check_kind_e kind;
    logic [7:0]  code;
    logic [5:0]  pos;
    logic [5:0]  len;
    logic        known;
  } dir_row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 s_axis_tlast_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_DATA_W-1:0]  m_axis_tdata_o;
  logic [M_USER_W-1:0]  m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  // Parser state as the checker sees it.
  logic [2:0]           sdes_state   = PH_STOPPED;
  int unsigned          hdr_seen     = 0;
  logic [6:0]           buf_wr       = '0;
  logic [6:0]           val_base     = '0;
  logic [7:0]           item_code    = '0;
  logic [7:0]           item_len     = '0;
  logic [7:0]           payload_todo = '0;
  logic                 item_stored  = 1'b0;

  res_item_t            sdes_results_q [$];
  in_item_t             packet_bytes_q [$];
  dir_row_t             dir_table [DIR_ROWS];

  int unsigned          src_idle_pct  = 0;
  int unsigned          sink_stall_pct = 0;
  int unsigned          quiet_cycles  = 0;
  int unsigned          mismatches    = 0;
  int unsigned          bytes_sent    = 0;
  int unsigned          packets_sent  = 0;
  int unsigned          results_seen  = 0;
  int unsigned          writes_seen   = 0;
  int unsigned          items_seen    = 0;
  int unsigned          ends_seen     = 0;

  rtcp_sdes_item_parser #(
    .BUF_BYTES    (BUF_SIZE),
    .HEADER_BYTES (HDR_BYTES)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Free-running clock.
  always begin
    clk_i = 1'b0;
    #(CLK_HALF);
    clk_i = 1'b1;
    #(CLK_HALF);
  end

  // Fills in the descriptor of the item that has just completed.
  function automatic res_item_t add_descriptor(res_item_t r);
    r.item_valid  = 1'b1;
    r.item_type   = item_code;
    r.item_offset = val_base[5:0];
    r.item_length = item_len[5:0];
    r.known_type  = (item_code >= TYPE_KNOWN_MIN) && (item_code <= TYPE_KNOWN_MAX);
    return r;
  endfunction

  // Advances the parser by one packet byte and returns the result it gives.
  function automatic res_item_t parse_sdes_byte(in_item_t it);
    res_item_t r;
    r = '0;
    if (it.first_byte) begin
      sdes_state   = PH_HEADER;
      hdr_seen     = 0;
      buf_wr       = '0;
      val_base     = '0;
      item_code    = '0;
      item_len     = '0;
      payload_todo = '0;
      item_stored  = 1'b0;
    end
    case (sdes_state)
      PH_HEADER: begin
        hdr_seen++;
        if (hdr_seen >= HDR_BYTES) begin
          hdr_seen   = 0;
          sdes_state = PH_TYPE;
        end
        if (it.last_byte) begin
          sdes_state   = PH_STOPPED;
          r.parse_done = 1'b1;
        end
      end
      PH_TYPE: begin
        item_code = it.pkt_byte;
        if (it.pkt_byte == TYPE_NULL || it.last_byte) begin
          sdes_state   = PH_STOPPED;
          r.parse_done = 1'b1;
        end else begin
          sdes_state = PH_LEN;
        end
      end
      PH_LEN: begin
        item_len     = it.pkt_byte;
        payload_todo = it.pkt_byte;
        val_base     = buf_wr;
        item_stored  = (int'(buf_wr) + int'(it.pkt_byte)) < int'(BUF_SIZE);
        if (it.pkt_byte == '0) begin
          if (item_stored) r = add_descriptor(r);
          sdes_state = PH_TYPE;
          if (it.last_byte) begin
            sdes_state   = PH_STOPPED;
            r.parse_done = 1'b1;
          end
        end else if (it.last_byte) begin
          sdes_state   = PH_STOPPED;
          r.parse_done = 1'b1;
        end else begin
          sdes_state = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (item_stored) begin
          r.store_valid = 1'b1;
          r.store_addr  = buf_wr[5:0];
          r.store_data  = it.pkt_byte;
          buf_wr++;
        end
        if (payload_todo != '0) payload_todo--;
        if (payload_todo == '0) begin
          if (item_stored) r = add_descriptor(r);
          sdes_state = PH_TYPE;
          if (it.last_byte) begin
            sdes_state   = PH_STOPPED;
            r.parse_done = 1'b1;
          end
        end else if (it.last_byte) begin
          // The item is cut short: its space in the buffer is given back.
          buf_wr       = val_base;
          sdes_state   = PH_STOPPED;
          r.parse_done = 1'b1;
        end
      end
      default: begin
        sdes_state = PH_STOPPED;
      end
    endcase
    return r;
  endfunction

  // Drives one byte with random idle cycles ahead of it and records what it
  // should produce once the transfer has taken place.
  task automatic send_sdes_byte(input in_item_t it, input bit typed, input res_item_t typed_exp);
    res_item_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= it.pkt_byte;
    s_axis_tuser_i  <= it.first_byte;
    s_axis_tlast_i  <= it.last_byte;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = parse_sdes_byte(it);
    sdes_results_q.push_back(typed ? typed_exp : predicted);
    bytes_sent++;
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sdes_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Builds one random packet: a header, a list of items and one of several
  // endings (clean, truncated, restarted by the next packet, or trailing noise).
  task automatic queue_packet(inout int unsigned parsed);
    logic [7:0]  body [$];
    int unsigned n_items;
    int unsigned code;
    int unsigned len;
    int unsigned roll;
    int unsigned cut;
    int unsigned junk;
    bit          ends_null;
    bit          mark_last;
    in_item_t    it;
    ends_null = 1'b0;
    mark_last = 1'b1;
    junk      = 0;
    repeat (HDR_BYTES) body.push_back(8'($urandom));
    n_items = $urandom_range(0, 6);
    for (int unsigned i = 0; i < n_items && !ends_null; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) code = $urandom_range(1, 7);
      else if (roll < 93) code = $urandom_range(8, 255);
      else code = 0;
      body.push_back(8'(code));
      if (code == 0) begin
        ends_null = 1'b1;
        junk      = $urandom_range(0, 3);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) len = $urandom_range(0, 6);
        else if (roll < 85) len = $urandom_range(7, 30);
        else if (roll < 97) len = $urandom_range(31, 70);
        else len = $urandom_range(71, 255);
        body.push_back(8'(len));
        repeat (len) body.push_back(8'($urandom));
      end
    end
    roll = $urandom_range(0, 99);
    if (roll >= 72 && roll < 87) begin
      cut = $urandom_range(0, body.size() - 1);
      while (body.size() > cut + 1) void'(body.pop_back());
    end else if (roll >= 87 && roll < 95) begin
      mark_last = 1'b0;
    end else if (roll >= 95) begin
      junk += $urandom_range(1, 4);
    end
    foreach (body[idx]) begin
      it.pkt_byte   = body[idx];
      it.first_byte = (idx == 0);
      it.last_byte  = mark_last && (idx == body.size() - 1);
      packet_bytes_q.push_back(it);
    end
    repeat (junk) begin
      it.pkt_byte   = 8'($urandom);
      it.first_byte = 1'b0;
      it.last_byte  = 1'($urandom_range(0, 1));
      packet_bytes_q.push_back(it);
    end
    parsed += body.size();
  endtask

  // Compares one field of a result and reports a mismatch.
  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Result side: random stalls, checking of each transfer, and the count of
  // cycles without any transfer for the watchdog.
  always @(posedge clk_i) begin : result_monitor
    res_item_t got;
    res_item_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.store_valid = m_axis_tuser_o[0];
      got.item_valid  = m_axis_tuser_o[1];
      got.store_addr  = m_axis_tdata_o[5:0];
      got.store_data  = m_axis_tdata_o[13:6];
      got.item_type   = m_axis_tdata_o[21:14];
      got.item_offset = m_axis_tdata_o[27:22];
      got.item_length = m_axis_tdata_o[33:28];
      got.known_type  = m_axis_tdata_o[34];
      got.parse_done  = m_axis_tlast_o;
      results_seen++;
      if (got.store_valid) writes_seen++;
      if (got.item_valid) items_seen++;
      if (got.parse_done) ends_seen++;
      if (sdes_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual 0x%0h/0x%0h/%0b",
                 $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        want = sdes_results_q.pop_front();
        compare_field("store_valid", want.store_valid, got.store_valid);
        compare_field("store_addr", want.store_addr, got.store_addr);
        compare_field("store_data", want.store_data, got.store_data);
        compare_field("item_valid", want.item_valid, got.item_valid);
        compare_field("item_type", want.item_type, got.item_type);
        compare_field("item_offset", want.item_offset, got.item_offset);
        compare_field("item_length", want.item_length, got.item_length);
        compare_field("known_type", want.known_type, got.known_type);
        compare_field("parse_done", want.parse_done, got.parse_done);
        compare_field("tdata padding", 0, m_axis_tdata_o[M_DATA_W-1:35]);
      end
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Watchdog: ends the run when no transfer has happened for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_CYCLES) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus: reset, the directed table, then random packets in four idling phases.
  initial begin
    res_item_t   want;
    in_item_t    it;
    int unsigned phase_bytes;

    dir_table = '{
      // Byte outside any packet is ignored.
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      // A first mark inside the header restarts; a packet ending there is short.
      '{8'h80, 1'b1, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h81, 1'b1, 1'b1, EXP_DONE,  8'h00, 6'd0, 6'd0, 1'b0},
      // Full header, then a zero-length CNAME and an unknown type with two bytes.
      '{8'h81, 1'b1, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hCA, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h12, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h34, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h56, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h78, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h01, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_DESC,  8'h01, 6'd0, 6'd0, 1'b1},
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h02, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_WRITE, 8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EXP_PRED,  8'h00, 6'd0, 6'd0, 1'b0},
      // A null type stops parsing; later bytes are ignored, last mark or not.
      '{8'h00, 1'b0, 1'b0, EXP_DONE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h5A, 1'b0, 1'b1, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      // An item cut short by the end of the packet.
      '{8'h80, 1'b1, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h03, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h03, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h55, 1'b0, 1'b0, EXP_WRITE, 8'h55, 6'd0, 6'd0, 1'b0},
      '{8'hAA, 1'b0, 1'b1, EXP_PRED,  8'h00, 6'd0, 6'd0, 1'b0},
      // A type byte that is the last byte of the packet.
      '{8'h80, 1'b1, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, EXP_IDLE,  8'h00, 6'd0, 6'd0, 1'b0},
      '{8'h04, 1'b0, 1'b1, EXP_DONE,  8'h00, 6'd0, 6'd0, 1'b0}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, with neither side idling.
    foreach (dir_table[r]) begin
      it.pkt_byte   = dir_table[r].pkt;
      it.first_byte = dir_table[r].first;
      it.last_byte  = dir_table[r].last;
      want = '0;
      case (dir_table[r].kind)
        EXP_DONE: begin
          want.parse_done = 1'b1;
        end
        EXP_DESC: begin
          want.item_valid  = 1'b1;
          want.item_type   = dir_table[r].code;
          want.item_offset = dir_table[r].pos;
          want.item_length = dir_table[r].len;
          want.known_type  = dir_table[r].known;
        end
        EXP_WRITE: begin
          want.store_valid = 1'b1;
          want.store_addr  = dir_table[r].pos;
          want.store_data  = dir_table[r].code;
        end
        default: begin
        end
      endcase
      send_sdes_byte(it, dir_table[r].kind != EXP_PRED, want);
    end

    // Random packets; the sender waits for all results at the end of each phase.
    for (int unsigned ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < RAND_BYTES / 4) begin
        queue_packet(phase_bytes);
        packets_sent++;
        while (packet_bytes_q.size() != 0) begin
          send_sdes_byte(packet_bytes_q.pop_front(), 1'b0, '0);
        end
      end
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d bytes in %0d random packets plus the directed table, %0d results.",
             bytes_sent, packets_sent, results_seen);
    $display("Seen %0d buffer writes, %0d item descriptors, %0d parse ends, %0d mismatches.",
             writes_seen, items_seen, ends_seen, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rsp_pkg.sv
src/rsp_in_reg.sv
src/rsp_core.sv
src/rsp_out_reg.sv
src/rtcp_sdes_item_parser.sv
src/rsp_checker.sv
verif/rtcp_sdes_item_parser_tb.sv
